// ----- src/skng_pkg.sv -----
// Shared types, constants and codes of the symmetric kNN graph builder.
`default_nettype none

package skng_pkg;

   localparam int VERTICES   = 64;
   localparam int VTX_BITS   = $clog2(VERTICES);
   localparam int COORD_BITS = 16;
   localparam int CFG_BITS   = 6;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int S_BITS     = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS  = COORD_BITS + 1;
   localparam int ISQ_BITS   = 2 * ROOT_BITS;
   localparam int PT_BITS    = 2 * COORD_BITS;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_BUILD = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] CSR_CLIENT_COUNT   = 2'd0;
   localparam logic [1:0] CSR_NEIGHBOR_COUNT = 2'd1;
   localparam logic [1:0] CSR_ROUND          = 2'd2;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [5:0]             vertex;
      logic signed [15:0]     coord_x;
      logic signed [15:0]     coord_y;
   } req_type;

   typedef struct packed {
      logic [5:0] neighbor;
      logic       has_neighbor;
      logic       last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_B_START, ST_B_CLIENT, ST_B_CLIENT_W,
      ST_K_RD, ST_K_ABS, ST_K_MUL, ST_K_SUM, ST_K_ROOT, ST_K_SQRT, ST_K_WR,
      ST_P_START, ST_P_SCAN, ST_P_RD, ST_P_CMP, ST_P_END, ST_ROW_WR,
      ST_Q_START, ST_Q_ROW, ST_Q_RD, ST_Q_COL, ST_Q_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic build_init;
      logic client_sel;
      logic pick_row_clr;
      logic client_cap;
      logic j_one;
      logic j_inc;
      logic key_abs;
      logic key_mul;
      logic key_sum;
      logic sqrt_start;
      logic key_wr;
      logic p_clr;
      logic scan_clr;
      logic pick_cmp;
      logic pick_take;
      logic row_wr;
      logic i_inc;
      logic v_cap;
      logic map_sel_v;
      logic qrow_cap;
      logic col_cap;
      logic e_clr;
      logic e_inc;
      logic emit_hit;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic cc_zero;
      logic round;
      logic j_is_n;
      logic j_is_last;
      logic i_is_n;
      logic picks_zero;
      logic p_last;
      logic found;
      logic sqrt_done;
      logic qrow_zero;
      logic qbit;
      logic q_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- src/symmetric_knn_graph_builder_core.sv -----
// A load writes one point into the point memory; a query first gathers row v and column v
//   of the map, then scans the indices in order (up to 64, ending at the last neighbor),
//   held by output stalls. A build computes, for each of n clients, the keys to all clients,
//   then one pick scan per neighbor; rounding passes each key through the bit-serial root.
// Throughput: one item at a time; the next beat is taken once the current one completes.
// Reset (synchronous, active high) restores the registers and empties the neighbor graph.
`default_nettype none

module symmetric_knn_graph_builder_core import skng_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   // request beats: load point, build, query
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_data,
   // result beats: one neighbor each, or a single empty beat for an empty row
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data,
   // register writes
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CFG_BITS-1:0] csr_data
);

   // The graph is kept as one pick row per client; a query ORs row v with
   // column v of all rows, which yields the symmetric neighbor set without
   // read-modify-write on the map. Rows past the last build's client count
   // read as empty, so no clearing pass is needed.
   cmd_type cmd;
   sts_type sts;

   skng_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   skng_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// ----- src/skng_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/skng_isqrt.sv -----
// Bit-serial integer square root with round-to-nearest result.
`default_nettype none

module skng_isqrt import skng_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [ISQ_BITS-1:0] value,
   output logic                     done,
   output logic [ROOT_BITS:0]       root_rounded
);

   localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

   logic [ISQ_BITS-1:0]  work_ff, work_in;
   logic [ROOT_BITS:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [ROOT_BITS+2:0] rem_t;
   logic [ROOT_BITS+2:0] trial;
   logic [ROOT_BITS+2:0] diff;

   always_comb begin
      rem_t   = {rem_ff, work_ff[ISQ_BITS-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = rem_t - trial;
      work_in = work_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_BITS'(ROOT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            work_in = {work_ff[ISQ_BITS-3:0], 2'b00};
            cnt_in  = cnt_ff - CNT_BITS'(1);
            if (rem_t >= trial) begin
               rem_in  = diff[ROOT_BITS:0];
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_t[ROOT_BITS:0];
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done         = busy_ff && (cnt_ff == '0);
   assign root_rounded = {1'b0, root_ff} +
                         (ROOT_BITS+1)'(rem_ff > {1'b0, root_ff});

endmodule

`default_nettype wire

// ----- src/skng_ctrl.sv -----
// Sequencer for load, build and query commands.
`default_nettype none

module skng_ctrl import skng_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_opcode,
   output logic            req_stall,
   output cmd_type         cmd,
   input  wire sts_type    sts
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_LOAD:  cmd.load = 1'b1;
                  OP_BUILD: state_in = ST_B_START;
                  OP_QUERY: begin
                     cmd.v_cap = 1'b1;
                     state_in  = ST_Q_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_B_START: begin
            cmd.build_init = 1'b1;
            state_in = sts.cc_zero ? ST_IDLE : ST_B_CLIENT;
         end
         ST_B_CLIENT: begin
            cmd.client_sel   = 1'b1;
            cmd.pick_row_clr = 1'b1;
            state_in = ST_B_CLIENT_W;
         end
         ST_B_CLIENT_W: begin
            cmd.client_cap = 1'b1;
            cmd.j_one      = 1'b1;
            state_in = ST_K_RD;
         end
         ST_K_RD:  state_in = ST_K_ABS;
         ST_K_ABS: begin
            cmd.key_abs = 1'b1;
            state_in = ST_K_MUL;
         end
         ST_K_MUL: begin
            cmd.key_mul = 1'b1;
            state_in = ST_K_SUM;
         end
         ST_K_SUM: begin
            cmd.key_sum = 1'b1;
            state_in = sts.round ? ST_K_ROOT : ST_K_WR;
         end
         ST_K_ROOT: begin
            cmd.sqrt_start = 1'b1;
            state_in = ST_K_SQRT;
         end
         ST_K_SQRT: begin
            if (sts.sqrt_done) begin
               state_in = ST_K_WR;
            end
         end
         ST_K_WR: begin
            cmd.key_wr = 1'b1;
            if (sts.j_is_n) begin
               state_in = ST_P_START;
            end else begin
               cmd.j_inc = 1'b1;
               state_in = ST_K_RD;
            end
         end
         ST_P_START: begin
            cmd.p_clr = 1'b1;
            state_in = sts.picks_zero ? ST_ROW_WR : ST_P_SCAN;
         end
         ST_P_SCAN: begin
            cmd.j_one    = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in = ST_P_RD;
         end
         ST_P_RD: state_in = ST_P_CMP;
         ST_P_CMP: begin
            cmd.pick_cmp = 1'b1;
            if (sts.j_is_n) begin
               state_in = ST_P_END;
            end else begin
               cmd.j_inc = 1'b1;
               state_in = ST_P_RD;
            end
         end
         ST_P_END: begin
            cmd.pick_take = sts.found;
            state_in = (!sts.found || sts.p_last) ? ST_ROW_WR : ST_P_SCAN;
         end
         ST_ROW_WR: begin
            cmd.row_wr = 1'b1;
            if (sts.i_is_n) begin
               state_in = ST_IDLE;
            end else begin
               cmd.i_inc = 1'b1;
               state_in = ST_B_CLIENT;
            end
         end
         ST_Q_START: begin
            cmd.map_sel_v = 1'b1;
            state_in = ST_Q_ROW;
         end
         ST_Q_ROW: begin
            cmd.qrow_cap = 1'b1;
            state_in = ST_Q_RD;
         end
         ST_Q_RD: state_in = ST_Q_COL;
         ST_Q_COL: begin
            cmd.col_cap = 1'b1;
            if (sts.j_is_last) begin
               cmd.e_clr = 1'b1;
               state_in = ST_Q_EMIT;
            end else begin
               cmd.j_inc = 1'b1;
               state_in = ST_Q_RD;
            end
         end
         ST_Q_EMIT: begin
            if (sts.qrow_zero) begin
               if (sts.out_free) begin
                  cmd.emit_empty = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!sts.qbit) begin
               cmd.e_inc = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit_hit = 1'b1;
               cmd.e_inc    = 1'b1;
               if (sts.q_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/skng_datapath.sv -----
// Point, key and pick-row memories, distance arithmetic and result register.
`default_nettype none

module skng_datapath import skng_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire req_type             req_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CFG_BITS-1:0] csr_data,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  wire logic                rsp_stall
);

   logic [CFG_BITS-1:0] cc_ff, nc_ff;
   logic                round_ff;

   logic [VTX_BITS-1:0] built_n_ff, i_ff, j_ff, v_ff, e_ff, best_ff;
   logic [CFG_BITS-1:0] p_ff, picks_ff;
   logic [CFG_BITS-1:0] cc_less;

   logic signed [COORD_BITS-1:0] ix_ff, iy_ff;
   logic [COORD_BITS-1:0]        ax_ff, ay_ff;
   logic [SQ_BITS-1:0]           sqx_ff, sqy_ff;
   logic [S_BITS-1:0]            s_ff, best_key_ff;
   logic                         found_ff;
   logic [VERTICES-1:0]          picked_ff, row_v_ff, qrow_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff;

   logic [PT_BITS-1:0]           pt_rdata;
   logic [S_BITS-1:0]            key_rdata, key_wdata;
   logic [VERTICES-1:0]          map_rdata, e_onehot;
   logic [VTX_BITS-1:0]          pt_raddr, map_raddr;
   logic signed [COORD_BITS-1:0] px, py;
   logic signed [COORD_BITS:0]   dx, dy, adx, ady;
   logic                         sqrt_done;
   logic [ROOT_BITS:0]           root_rounded;
   logic                         eligible, v_ok, j_ok, out_free, q_last;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff    <= CFG_BITS'(1);
         nc_ff    <= CFG_BITS'(20);
         round_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLIENT_COUNT:   cc_ff    <= csr_data;
            CSR_NEIGHBOR_COUNT: nc_ff    <= csr_data;
            CSR_ROUND:          round_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // memories
   assign pt_raddr  = cmd.client_sel ? i_ff : j_ff;
   assign map_raddr = cmd.map_sel_v ? v_ff : j_ff;

   skng_ram #(.WIDTH(PT_BITS), .DEPTH(VERTICES)) u_points (
      .clock (clock),
      .we    (cmd.load),
      .waddr (req_data.vertex),
      .wdata ({req_data.coord_y, req_data.coord_x}),
      .raddr (pt_raddr),
      .rdata (pt_rdata)
   );

   skng_ram #(.WIDTH(S_BITS), .DEPTH(VERTICES)) u_keys (
      .clock (clock),
      .we    (cmd.key_wr),
      .waddr (j_ff),
      .wdata (key_wdata),
      .raddr (j_ff),
      .rdata (key_rdata)
   );

   skng_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_picks (
      .clock (clock),
      .we    (cmd.row_wr),
      .waddr (i_ff),
      .wdata (picked_ff),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   skng_isqrt u_isqrt (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.sqrt_start),
      .value        (ISQ_BITS'(s_ff)),
      .done         (sqrt_done),
      .root_rounded (root_rounded)
   );

   // distance arithmetic
   assign px  = pt_rdata[COORD_BITS-1:0];
   assign py  = pt_rdata[PT_BITS-1:COORD_BITS];
   assign dx  = {ix_ff[COORD_BITS-1], ix_ff} - {px[COORD_BITS-1], px};
   assign dy  = {iy_ff[COORD_BITS-1], iy_ff} - {py[COORD_BITS-1], py};
   assign adx = dx[COORD_BITS] ? -dx : dx;
   assign ady = dy[COORD_BITS] ? -dy : dy;
   assign key_wdata = round_ff ? S_BITS'(root_rounded) : s_ff;

   assign cc_less  = cc_ff - CFG_BITS'(1);
   assign eligible = (j_ff != i_ff) && !picked_ff[j_ff];
   assign v_ok     = (v_ff != '0) && (v_ff <= built_n_ff);
   assign j_ok     = (j_ff != '0) && (j_ff <= built_n_ff);
   assign e_onehot = VERTICES'(1) << e_ff;
   assign q_last   = ((qrow_ff & ~e_onehot) == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // control counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         built_n_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.build_init) begin
            built_n_ff <= VTX_BITS'(cc_ff);
         end
         if (cmd.emit_hit || cmd.emit_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         i_ff     <= VTX_BITS'(1);
         picks_ff <= (nc_ff < cc_less) ? nc_ff : cc_less;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + VTX_BITS'(1);
      end
      if (cmd.j_one) begin
         j_ff <= VTX_BITS'(1);
      end else if (cmd.qrow_cap) begin
         j_ff <= '0;
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + VTX_BITS'(1);
      end
      if (cmd.client_cap) begin
         ix_ff <= px;
         iy_ff <= py;
      end
      if (cmd.key_abs) begin
         ax_ff <= adx[COORD_BITS-1:0];
         ay_ff <= ady[COORD_BITS-1:0];
      end
      if (cmd.key_mul) begin
         sqx_ff <= SQ_BITS'(ax_ff) * SQ_BITS'(ax_ff);
         sqy_ff <= SQ_BITS'(ay_ff) * SQ_BITS'(ay_ff);
      end
      if (cmd.key_sum) begin
         s_ff <= S_BITS'(sqx_ff) + S_BITS'(sqy_ff);
      end
      if (cmd.pick_row_clr) begin
         picked_ff <= '0;
      end else if (cmd.pick_take) begin
         picked_ff[best_ff] <= 1'b1;
      end
      if (cmd.p_clr) begin
         p_ff <= '0;
      end else if (cmd.pick_take) begin
         p_ff <= p_ff + CFG_BITS'(1);
      end
      if (cmd.scan_clr) begin
         found_ff <= 1'b0;
      end else if (cmd.pick_cmp && eligible &&
                   (!found_ff || (key_rdata < best_key_ff))) begin
         found_ff    <= 1'b1;
         best_ff     <= j_ff;
         best_key_ff <= key_rdata;
      end
      if (cmd.v_cap) begin
         v_ff <= req_data.vertex;
      end
      if (cmd.qrow_cap) begin
         row_v_ff <= v_ok ? map_rdata : '0;
         qrow_ff  <= '0;
      end else if (cmd.col_cap) begin
         qrow_ff[j_ff] <= row_v_ff[j_ff] | (map_rdata[v_ff] & j_ok);
      end else if (cmd.emit_hit) begin
         qrow_ff <= qrow_ff & ~e_onehot;
      end
      if (cmd.e_clr) begin
         e_ff <= '0;
      end else if (cmd.e_inc) begin
         e_ff <= e_ff + VTX_BITS'(1);
      end
      if (cmd.emit_hit) begin
         rsp_data_ff.neighbor     <= e_ff;
         rsp_data_ff.has_neighbor <= 1'b1;
         rsp_data_ff.last         <= q_last;
      end else if (cmd.emit_empty) begin
         rsp_data_ff.neighbor     <= '0;
         rsp_data_ff.has_neighbor <= 1'b0;
         rsp_data_ff.last         <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      sts            = '0;
      sts.cc_zero    = (cc_ff == '0);
      sts.round      = round_ff;
      sts.j_is_n     = (j_ff == built_n_ff);
      sts.j_is_last  = (j_ff == VTX_BITS'(VERTICES - 1));
      sts.i_is_n     = (i_ff == built_n_ff);
      sts.picks_zero = (picks_ff == '0);
      sts.p_last     = ((p_ff + CFG_BITS'(1)) == picks_ff);
      sts.found      = found_ff;
      sts.sqrt_done  = sqrt_done;
      sts.qrow_zero  = (qrow_ff == '0);
      sts.qbit       = qrow_ff[e_ff];
      sts.q_last     = q_last;
      sts.out_free   = out_free;
   end

endmodule

`default_nettype wire

// ----- src/skng_checker.sv -----
// Port-level checks of the graph builder, bound to the top level.
`default_nettype none

module skng_checker import skng_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_neighbor |-> rsp_data.last && rsp_data.neighbor == '0)
      else $error("empty result malformed");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_QUERY |=> req_stall)
      else $error("query beat did not occupy the block");

endmodule

bind symmetric_knn_graph_builder_core skng_checker u_skng_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/tb_symmetric_knn_graph_builder_core.sv -----
// Self-checking testbench for the symmetric kNN graph builder core.
`timescale 1ns / 1ps
`default_nettype none

module tb_symmetric_knn_graph_builder_core;
   import skng_pkg::*;

   // Opcode 3 has no meaning in the block; it must be dropped without results.
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int MAX_LIST = 62;
   localparam int DRAIN_CYCLES = 200;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = '0;
   logic [CFG_BITS-1:0] csr_data = '0;

   symmetric_knn_graph_builder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the block: points, graph rows and registers.
   logic signed [COORD_BITS-1:0] shadow_x [VERTICES];
   logic signed [COORD_BITS-1:0] shadow_y [VERTICES];
   bit [VERTICES-1:0]            graph_row [VERTICES];
   bit [VERTICES-1:0]            point_loaded;
   logic [CFG_BITS-1:0]          cfg_clients;
   logic [CFG_BITS-1:0]          cfg_picks;
   logic                         cfg_round;

   rsp_type neighbor_q [$];   // neighbor beats still owed by the block
   int      mismatches  = 0;
   int      items_sent  = 0;
   int      beats_seen  = 0;
   int      builds_sent = 0;
   int      burst_left  = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("timeout: %0d neighbor beats still owed", neighbor_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Floor square root, digit by digit.
   function automatic longint unsigned root_floor(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Rank key of a point pair: squared distance, or the rounded distance.
   function automatic longint unsigned pair_key(input int a, input int b);
      longint dx, dy;
      longint unsigned s, r;
      dx = longint'(shadow_x[a]) - longint'(shadow_x[b]);
      dy = longint'(shadow_y[a]) - longint'(shadow_y[b]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      s = dx * dx + dy * dy;
      if (!cfg_round) return s;
      r = root_floor(s);
      // round half up: sqrt(s) >= r + 0.5 exactly when s > r*r + r
      if (s > r * r + r) r++;
      return r;
   endfunction

   // Recompute the symmetric graph the way a build does.
   function automatic void rebuild_graph();
      int n, picks, best;
      longint unsigned k, best_key;
      bit found;
      bit [VERTICES-1:0] taken;
      n = cfg_clients;
      foreach (graph_row[r]) graph_row[r] = '0;
      if (n == 0) return;
      picks = (cfg_picks > n - 1) ? n - 1 : cfg_picks;
      for (int i = 1; i <= n; i++) begin
         taken = '0;
         for (int p = 0; p < picks; p++) begin
            found = 0;
            best = 0;
            best_key = 0;
            for (int j = 1; j <= n; j++) begin
               if (j == i || taken[j]) continue;
               k = pair_key(i, j);
               // strict compare keeps the lower index on a tie
               if (!found || k < best_key) begin
                  found = 1;
                  best = j;
                  best_key = k;
               end
            end
            if (!found) break;
            taken[best] = 1;
            graph_row[i][best] = 1;
            graph_row[best][i] = 1;
         end
      end
   endfunction

   // Advance the shadow model by one accepted request beat.
   function automatic void apply_request(input req_type d);
      rsp_type b;
      int cnt;
      case (d.opcode)
         OP_LOAD: begin
            shadow_x[d.vertex] = d.coord_x;
            shadow_y[d.vertex] = d.coord_y;
            point_loaded[d.vertex] = 1;
         end
         OP_BUILD: rebuild_graph();
         OP_QUERY: begin
            cnt = 0;
            for (int j = 0; j < VERTICES && cnt < MAX_LIST; j++) begin
               if (!graph_row[d.vertex][j]) continue;
               b.neighbor = VTX_BITS'(j);
               b.has_neighbor = 1;
               b.last = 0;
               neighbor_q.insert(neighbor_q.size(), b);
               cnt++;
            end
            if (cnt == 0) begin
               b = '0;
               b.last = 1;
               neighbor_q.insert(neighbor_q.size(), b);
            end else begin
               neighbor_q[neighbor_q.size() - 1].last = 1;
            end
         end
         default: ;
      endcase
   endfunction

   // Send one beat. The sender runs in bursts; between bursts it may drop valid for a gap.
   task automatic send_item(input logic [1:0] op, input int vtx,
                            input int x = 0, input int y = 0);
      req_type d;
      int gap;
      d.opcode = op;
      d.vertex = VTX_BITS'(vtx);
      d.coord_x = COORD_BITS'(x);
      d.coord_y = COORD_BITS'(y);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      apply_request(d);
      burst_left--;
      items_sent++;
      if (op == OP_BUILD) builds_sent++;
   endtask

   // Issue a query, then hold until every owed beat has arrived and the block rests.
   task automatic wait_idle();
      send_item(OP_QUERY, $urandom_range(0, VERTICES - 1));
      req_valid <= 1'b0;
      burst_left = 0;
      while (neighbor_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CFG_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CLIENT_COUNT:   cfg_clients = CFG_BITS'(value);
         CSR_NEIGHBOR_COUNT: cfg_picks = CFG_BITS'(value);
         CSR_ROUND:          cfg_round = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input int n, input int k, input int rnd);
      write_reg(CSR_CLIENT_COUNT, n);
      write_reg(CSR_NEIGHBOR_COUNT, k);
      write_reg(CSR_ROUND, rnd);
   endtask

   // Load every client point still missing, so a build never reads an empty slot.
   task automatic fill_clients(input int span);
      for (int v = 1; v <= cfg_clients; v++)
         if (!point_loaded[v])
            send_item(OP_LOAD, v, $signed($urandom_range(0, 2 * span)) - span,
                      $signed($urandom_range(0, 2 * span)) - span);
   endtask

   // Check each result beat against the oldest owed one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (neighbor_q.size() == 0) begin
            report($sformatf("unexpected beat neighbor=%0d", rsp_data.neighbor));
         end else begin
            want = neighbor_q.pop_front();
            if (rsp_data.neighbor !== want.neighbor)
               report($sformatf("neighbor %0d, want %0d", rsp_data.neighbor,
                                want.neighbor));
            if (rsp_data.has_neighbor !== want.has_neighbor)
               report($sformatf("has_neighbor %0b, want %0b",
                                rsp_data.has_neighbor, want.has_neighbor));
            if (rsp_data.last !== want.last)
               report($sformatf("last %0b, want %0b", rsp_data.last, want.last));
         end
      end
   end

   // Receiver stall: switch between free flow, light, periodic and heavy back-pressure.
   initial begin
      int mode = 0;
      int run_left = 0;
      int cyc = 0;
      forever begin
         @(posedge clock);
         if (run_left == 0) begin
            mode = $urandom_range(0, 3);
            run_left = $urandom_range(20, 300);
         end
         run_left--;
         cyc++;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= (cyc % 5 >= 3);
            default: rsp_stall <= ($urandom_range(0, 99) < 80);
         endcase
      end
   end

   // After reset the map is empty: every query returns one empty beat.
   task automatic test_reset_state();
      send_item(OP_QUERY, 0);
      send_item(OP_QUERY, 1);
      send_item(OP_QUERY, VERTICES - 1);
      wait_idle();
   endtask

   // Extreme coordinates, ties, rounding, unused opcode, depot and stale map.
   task automatic test_directed();
      set_config(4, 2, 1);
      send_item(OP_LOAD, 0, 0, 0);
      send_item(OP_LOAD, 1, -32768, -32768);
      send_item(OP_LOAD, 2, 32767, 32767);
      send_item(OP_LOAD, 3, -32768, 32767);
      send_item(OP_LOAD, 4, 32767, -32768);
      send_item(OP_SPARE, 5, -1, -1);
      send_item(OP_BUILD, 0);
      send_item(OP_QUERY, 1);
      send_item(OP_QUERY, 4);
      send_item(OP_QUERY, 0);
      send_item(OP_QUERY, 5);
      wait_idle();
      // stale map: new registers and points leave the graph alone until a rebuild
      set_config(0, 63, 0);
      send_item(OP_LOAD, 2, -32768, -32768);
      send_item(OP_QUERY, 2);
      send_item(OP_BUILD, 0);
      send_item(OP_QUERY, 2);
      wait_idle();
      // equal distances on a grid: ties pick the lower index
      set_config(4, 1, 0);
      send_item(OP_LOAD, 1, 0, 0);
      send_item(OP_LOAD, 2, 1, 0);
      send_item(OP_LOAD, 3, -1, 0);
      send_item(OP_LOAD, 4, 0, 1);
      send_item(OP_BUILD, 63);
      send_item(OP_QUERY, 1);
      wait_idle();
   endtask

   // Random phases on small graphs: registers, loads, build, queries.
   task automatic test_random_graphs();
      int n, span, op_pick;
      while (items_sent < 400) begin
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(0, 1);
            1:       n = $urandom_range(11, 16);
            default: n = $urandom_range(2, 10);
         endcase
         set_config(n, $urandom_range(0, 9) == 0 ? 63 : $urandom_range(0, n + 1),
                    $urandom_range(0, 1));
         span = ($urandom_range(0, 1) == 0) ? 4 : 32767;
         // queries before the rebuild see the map of the previous phase
         send_item(OP_QUERY, $urandom_range(0, n + 1));
         fill_clients(span);
         repeat ($urandom_range(2, 8)) begin
            op_pick = $urandom_range(0, 9);
            if (op_pick == 0)
               send_item(OP_SPARE, $urandom_range(0, 63),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            else if (op_pick < 3)
               send_item(OP_LOAD, $urandom_range(0, 63),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
               send_item(OP_LOAD, $urandom_range(0, n + 1),
                         $signed($urandom_range(0, 2 * span)) - span,
                         $signed($urandom_range(0, 2 * span)) - span);
         end
         send_item(OP_BUILD, $urandom_range(0, 63));
         repeat ($urandom_range(4, 12))
            send_item(OP_QUERY, $urandom_range(0, 5) == 0 ? $urandom_range(0, 63)
                                                          : $urandom_range(0, n));
         wait_idle();
      end
   endtask

   // Largest graph: all 63 clients, every other client picked, so rows run full length.
   task automatic test_full_graph();
      set_config(63, 63, 1);
      fill_clients(32767);
      send_item(OP_BUILD, 0);
      for (int v = 0; v < VERTICES; v += 7) send_item(OP_QUERY, v);
      send_item(OP_QUERY, VERTICES - 1);
      wait_idle();
   endtask

   initial begin
      point_loaded = '0;
      foreach (graph_row[r]) graph_row[r] = '0;
      foreach (shadow_x[r]) begin
         shadow_x[r] = '0;
         shadow_y[r] = '0;
      end
      cfg_clients = 1;
      cfg_picks = 20;
      cfg_round = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_directed();
      test_random_graphs();
      test_full_graph();

      req_valid <= 1'b0;
      while (neighbor_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      foreach (neighbor_q[i]) report("owed beat never arrived");

      $display("covered %0d request beats with %0d graph builds, %0d neighbor beats checked",
               items_sent, builds_sent, beats_seen);
      $display("graphs from 0 to 63 clients, rounding on and off, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
